/* src/lpfd_pkg.sv */
// Package for the light profile fraction depth finder.
// Holds widths, the per-mille fraction table and the token and result types.
// No dependencies.
package lpfd_pkg;

   localparam int DEFAULT_DEPTHS = 101;
   localparam int NUM_LEVELS     = 11;
   localparam int NUM_RESULTS    = NUM_LEVELS + 1;
   localparam int SAMPLE_W       = 24;
   localparam int BOTTOM_W       = 7;
   localparam int LEVEL_W        = 4;
   localparam int INDEX_W        = 7;
   localparam int LEFT_W         = $clog2(NUM_RESULTS + 1);
   // sample * 1000 and surface * 900 both fit in 34 signed bits.
   localparam int PROD_W         = 34;
   localparam int SURFACE_SCALE  = 1000;

   localparam logic [BOTTOM_W-1:0] BOTTOM_RESET = BOTTOM_W'(101);
   localparam logic [LEVEL_W-1:0]  LAST_LEVEL   = LEVEL_W'(NUM_LEVELS);

   // Fractions of the surface light, in parts per thousand.
   localparam int FRACTION_PER_MILLE [NUM_LEVELS] =
      '{900, 800, 700, 600, 500, 400, 300, 200, 100, 10, 1};

   // Final answer of one optical level.
   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] where;
   } level_result_type;

   // One sample on its way down the row of level cells.
   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic                     search;
      logic                     full_scan;
      logic signed [PROD_W-1:0] scaled_sample;
      logic signed [SAMPLE_W-1:0] surface;
      logic [INDEX_W-1:0]       idx;
      logic [INDEX_W-1:0]       deepest;
      level_result_type [NUM_LEVELS-1:0] results;
   } token_type;

endpackage

/* src/lpfd_ifs.sv */
// Channel interfaces of the light profile fraction depth finder.
// Depends on lpfd_pkg for field widths.
interface lpfd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [lpfd_pkg::SAMPLE_W-1:0] light_sample;

   modport source (output valid, output light_sample, input ready);
   modport sink (input valid, input light_sample, output ready);
endinterface

interface lpfd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lpfd_pkg::LEVEL_W-1:0]     level;
   logic                             level_valid;
   logic [lpfd_pkg::INDEX_W-1:0]     crossing_index;
   logic [lpfd_pkg::INDEX_W-1:0]     deepest_plus_one;
   logic                             last_result;

   modport source (output valid, output level, output level_valid, output crossing_index,
                   output deepest_plus_one, output last_result, input ready);
   modport sink (input valid, input level, input level_valid, input crossing_index,
                 input deepest_plus_one, input last_result, output ready);
endinterface

interface lpfd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lpfd_pkg::BOTTOM_W-1:0]  bottom_count;

   modport source (output valid, output bottom_count, input ready);
   modport sink (input valid, input bottom_count, output ready);
endinterface

/* src/light_profile_fraction_depth_finder.sv */
// Top level of the light profile fraction depth finder.
// Depends on lpfd_pkg, lpfd_ifs, lpfd_entry, lpfd_cell and lpfd_emit.
//
// Usage:
//   req_ch carries one light sample per request, surface first, DEPTHS
//   requests per profile. rsp_ch returns twelve results after the last
//   sample of each profile, level 0 through level 11, the last one flagged
//   by last_result. csr_ch writes bottom_count, the number of samples from
//   the surface that are searched; it is always ready.
//   One sample is taken per cycle while req_ch.ready is high. Each sample
//   walks a row of eleven level cells, one cell per cycle, through the entry
//   register and the eleven cell registers before the emitter loads the
//   end-of-profile token; the results then leave at one per cycle, when the
//   receiver is ready, while the next profile streams in behind them.
//   The emitter holds one profile's results. When a profile ends while the
//   previous twelve results are still being sent, the whole cell row holds
//   and req_ch.ready drops until the emitter frees up.
//   When the receiver stalls, the current result holds and the row stops
//   as soon as the next end-of-profile sample reaches the emitter.
//   Reset clears the sample count, all level state and pending results,
//   and sets bottom_count to 101.
module light_profile_fraction_depth_finder #(
   parameter int DEPTHS = lpfd_pkg::DEFAULT_DEPTHS
) (
   input  logic      clock,
   input  logic      reset,
   lpfd_req_if.sink  req_ch,
   lpfd_rsp_if.source rsp_ch,
   lpfd_csr_if.sink  csr_ch
);
   import lpfd_pkg::*;

   logic [BOTTOM_W-1:0] bottom_count_ff;
   token_type           chain [NUM_LEVELS + 1];
   logic                advance;
   logic                load_ok;

   // Configuration register.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_count_ff <= BOTTOM_RESET;
      end else if (csr_ch.valid) begin
         bottom_count_ff <= csr_ch.bottom_count;
      end
   end

   // The row moves unless an end-of-profile token waits for the emitter.
   assign advance      = !(chain[NUM_LEVELS].valid && chain[NUM_LEVELS].last) || load_ok;
   assign req_ch.ready = advance;

   lpfd_entry #(
      .DEPTHS(DEPTHS)
   ) u_entry (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_ch.valid),
      .light_sample(req_ch.light_sample),
      .bottom_count(bottom_count_ff),
      .token_out   (chain[0])
   );

   // Row of level cells, one per fraction.
   for (genvar k = 0; k < NUM_LEVELS; k++) begin : g_cell
      lpfd_cell #(
         .DEPTHS(DEPTHS),
         .LEVEL (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .token_in (chain[k]),
         .token_out(chain[k + 1])
      );
   end

   lpfd_emit u_emit (
      .clock   (clock),
      .reset   (reset),
      .token_in(chain[NUM_LEVELS]),
      .advance (advance),
      .load_ok (load_ok),
      .rsp_ch  (rsp_ch)
   );

   // The row only stalls while results are pending.
   assert property (@(posedge clock) disable iff (reset)
      (chain[NUM_LEVELS].valid && chain[NUM_LEVELS].last && !advance) |-> rsp_ch.valid)
      else $error("row stalled with no results pending");

   // Results of a profile follow each other in level order.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_result) |=>
         (rsp_ch.valid && (rsp_ch.level == $past(rsp_ch.level) + LEVEL_W'(1))))
      else $error("result sequence broken");

   // Level 0 is always found at the surface.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.level == '0)) |->
         (rsp_ch.level_valid && (rsp_ch.crossing_index == '0)))
      else $error("level 0 result wrong");

   // The deepest index is shared by all results of one profile.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_result) |=>
         $stable(rsp_ch.deepest_plus_one))
      else $error("deepest index changed within a profile");

endmodule

/* src/lpfd_entry.sv */
// Entry stage: counts samples, keeps the surface value and builds the token
// that travels down the level cells. Depends on lpfd_pkg.
module lpfd_entry #(
   parameter int DEPTHS = lpfd_pkg::DEFAULT_DEPTHS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 req_valid,
   input  logic signed [lpfd_pkg::SAMPLE_W-1:0] light_sample,
   input  logic [lpfd_pkg::BOTTOM_W-1:0]        bottom_count,
   output lpfd_pkg::token_type                  token_out
);
   import lpfd_pkg::*;

   localparam int IDX_W = $clog2(DEPTHS);
   localparam int CMP_W = ((IDX_W > BOTTOM_W) ? IDX_W : BOTTOM_W) + 1;

   logic [IDX_W-1:0]           sample_count_ff, sample_count_in;
   logic signed [SAMPLE_W-1:0] surface_ff, surface_in;
   token_type                  token_ff, token_in;
   logic                       accept;
   logic                       is_last;

   assign accept  = req_valid && advance;
   assign is_last = (sample_count_ff == IDX_W'(DEPTHS - 1));

   // The surface sample is its own reference.
   always_comb begin
      surface_in = (sample_count_ff == '0) ? light_sample : surface_ff;
      sample_count_in = is_last ? '0 : sample_count_ff + IDX_W'(1);

      token_in               = '0;
      token_in.valid         = req_valid;
      token_in.last          = is_last;
      token_in.search        = (CMP_W'(sample_count_ff) < CMP_W'(bottom_count));
      token_in.full_scan     = (CMP_W'(bottom_count) >= CMP_W'(DEPTHS));
      token_in.scaled_sample = PROD_W'(light_sample) * PROD_W'(SURFACE_SCALE);
      token_in.surface       = surface_in;
      token_in.idx           = INDEX_W'(sample_count_ff);
      // Level 0 is always valid at index 0.
      token_in.deepest       = '0;
   end

   // Sample position and surface register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= '0;
         surface_ff      <= '0;
      end else if (accept) begin
         sample_count_ff <= sample_count_in;
         surface_ff      <= surface_in;
      end
   end

   // Token register feeding the first cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else if (advance) begin
         token_ff <= token_in;
      end
   end

   assign token_out = token_ff;

endmodule

/* src/lpfd_cell.sv */
// One level cell: tracks the crossing of one fraction of the surface light
// and writes its answer into the end-of-profile token. Depends on lpfd_pkg.
module lpfd_cell #(
   parameter int DEPTHS = lpfd_pkg::DEFAULT_DEPTHS,
   parameter int LEVEL  = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  lpfd_pkg::token_type token_in,
   output lpfd_pkg::token_type token_out
);
   import lpfd_pkg::*;

   logic                     done_ff, done_in;
   logic                     bad_ff, bad_in;
   logic [INDEX_W-1:0]       index_ff, index_in;
   token_type                token_ff, token_next;
   logic signed [PROD_W-1:0] threshold;
   logic                     step, negative, below;
   level_result_type         answer;

   assign threshold = PROD_W'(token_in.surface) * PROD_W'(FRACTION_PER_MILLE[LEVEL]);
   assign step      = token_in.valid && token_in.search && !done_ff;
   assign negative  = token_in.scaled_sample[PROD_W-1];
   assign below     = (token_in.scaled_sample < threshold);

   // A missing sample closes the level as invalid before the crossing test.
   always_comb begin
      done_in  = done_ff || (step && (negative || below));
      bad_in   = bad_ff || (step && negative);
      index_in = (step && !negative && below) ? token_in.idx : index_ff;

      if (done_in) begin
         answer.valid = !bad_in;
         answer.where = bad_in ? '0 : index_in;
      end else begin
         answer.valid = token_in.full_scan;
         answer.where = token_in.full_scan ? INDEX_W'(DEPTHS - 1) : '0;
      end

      token_next = token_in;
      if (token_in.last) begin
         token_next.results[LEVEL] = answer;
         if (answer.valid) begin
            token_next.deepest = answer.where;
         end
      end
   end

   // Level state; cleared as the last sample of a profile passes.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= 1'b0;
         bad_ff   <= 1'b0;
         index_ff <= '0;
      end else if (advance && token_in.valid) begin
         if (token_in.last) begin
            done_ff  <= 1'b0;
            bad_ff   <= 1'b0;
            index_ff <= '0;
         end else begin
            done_ff  <= done_in;
            bad_ff   <= bad_in;
            index_ff <= index_in;
         end
      end
   end

   // Hand the token to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else if (advance) begin
         token_ff <= token_next;
      end
   end

   assign token_out = token_ff;

endmodule

/* src/lpfd_emit.sv */
// Result emitter: holds the twelve answers of a finished profile and sends
// them one per handshake, level 0 first. Depends on lpfd_pkg and lpfd_ifs.
module lpfd_emit (
   input  logic                clock,
   input  logic                reset,
   input  lpfd_pkg::token_type token_in,
   input  logic                advance,
   output logic                load_ok,
   lpfd_rsp_if.source          rsp_ch
);
   import lpfd_pkg::*;

   level_result_type [NUM_RESULTS-1:0] hold_ff, hold_in;
   logic [INDEX_W-1:0]                 deepest_ff;
   logic [LEFT_W-1:0]                  left_ff, left_in;
   logic [LEVEL_W-1:0]                 level_ff, level_in;
   logic                               send;
   logic                               load;

   assign send    = rsp_ch.valid && rsp_ch.ready;
   assign load_ok = (left_ff == '0) || ((left_ff == LEFT_W'(1)) && rsp_ch.ready);
   assign load    = token_in.valid && token_in.last && advance;

   // Load a fresh set, or shift the held answers toward the output.
   always_comb begin
      hold_in  = hold_ff;
      left_in  = left_ff;
      level_in = level_ff;
      if (load) begin
         hold_in[0].valid = 1'b1;
         hold_in[0].where = '0;
         for (int k = 0; k < NUM_LEVELS; k++) begin
            hold_in[k + 1] = token_in.results[k];
         end
         left_in  = LEFT_W'(NUM_RESULTS);
         level_in = '0;
      end else if (send) begin
         for (int k = 0; k < NUM_RESULTS - 1; k++) begin
            hold_in[k] = hold_ff[k + 1];
         end
         left_in  = left_ff - LEFT_W'(1);
         level_in = level_ff + LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         level_ff <= '0;
      end else begin
         left_ff  <= left_in;
         level_ff <= level_in;
      end
   end

   // Answer payload needs no reset.
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (load) begin
         deepest_ff <= token_in.deepest;
      end
   end

   assign rsp_ch.valid            = (left_ff != '0);
   assign rsp_ch.level            = level_ff;
   assign rsp_ch.level_valid      = hold_ff[0].valid;
   assign rsp_ch.crossing_index   = hold_ff[0].where;
   assign rsp_ch.deepest_plus_one = deepest_ff + INDEX_W'(1);
   assign rsp_ch.last_result      = (level_ff == LAST_LEVEL);

endmodule

/* dv/lpfd_depth_checker.sv */
`timescale 1ns / 1ps
// Checker for the light profile fraction depth finder: watches the request, result and
// register channels, predicts the twelve level results of each profile and compares them.
// Depends on lpfd_pkg and the channel interfaces in lpfd_ifs.
module lpfd_depth_checker #(
   parameter int DEPTHS = lpfd_pkg::DEFAULT_DEPTHS
) (
   input  logic clock,
   input  logic reset,
   lpfd_req_if  req_ch,
   lpfd_rsp_if  rsp_ch,
   lpfd_csr_if  csr_ch,
   output int   mismatches,
   output int   answers_due_count,
   output int   answers_seen,
   output int   samples_seen
);
   import lpfd_pkg::*;

   // Fractions of the surface light in parts per thousand, level 1 first.
   localparam int PER_MILLE [NUM_LEVELS] = '{900, 800, 700, 600, 500, 400, 300, 200, 100, 10, 1};
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               level_valid;
      logic [INDEX_W-1:0] crossing_index;
      logic [INDEX_W-1:0] deepest_plus_one;
      logic               last_result;
   } level_answer_type;

   // Level results still owed by the block, oldest first.
   level_answer_type answers_due[$];

   // Own copy of the register and of the profile scan state.
   int     bottom_setting;
   int     sample_idx;
   longint surface;
   bit     closed   [NUM_LEVELS];
   bit     missing  [NUM_LEVELS];
   int     cross_at [NUM_LEVELS];

   function automatic void clear_profile();
      sample_idx = 0;
      surface    = 0;
      for (int k = 0; k < NUM_LEVELS; k++) begin
         closed[k]   = 1'b0;
         missing[k]  = 1'b0;
         cross_at[k] = 0;
      end
   endfunction

   // Advance the scan by one sample; at the end of a profile queue its twelve answers.
   function automatic void take_sample(input logic signed [SAMPLE_W-1:0] sample);
      int               limit;
      longint           value;
      bit               ok [NUM_RESULTS];
      int               where_at [NUM_RESULTS];
      int               deepest;
      level_answer_type answer;
      value = sample;
      limit = (bottom_setting > DEPTHS) ? DEPTHS : bottom_setting;
      if (sample_idx == 0) surface = value;

      // A missing sample closes every open level as bad, even one it would cross.
      if (sample_idx < limit) begin
         for (int k = 0; k < NUM_LEVELS; k++) begin
            if (!closed[k]) begin
               if (value < 0) begin
                  closed[k]  = 1'b1;
                  missing[k] = 1'b1;
               end else if (value * 1000 < surface * PER_MILLE[k]) begin
                  closed[k]   = 1'b1;
                  cross_at[k] = sample_idx;
               end
            end
         end
      end

      if (sample_idx + 1 < DEPTHS) begin
         sample_idx++;
         return;
      end

      // Settle open levels: they only count when the whole grid was searched.
      ok[0]       = 1'b1;
      where_at[0] = 0;
      for (int k = 0; k < NUM_LEVELS; k++) begin
         if (closed[k]) begin
            ok[k + 1]       = !missing[k];
            where_at[k + 1] = missing[k] ? 0 : cross_at[k];
         end else if (limit == DEPTHS) begin
            ok[k + 1]       = 1'b1;
            where_at[k + 1] = DEPTHS - 1;
         end else begin
            ok[k + 1]       = 1'b0;
            where_at[k + 1] = 0;
         end
      end
      deepest = 0;
      for (int k = NUM_RESULTS - 1; k >= 0; k--) begin
         if (ok[k]) begin
            deepest = where_at[k];
            break;
         end
      end
      for (int k = 0; k < NUM_RESULTS; k++) begin
         answer.level            = LEVEL_W'(k);
         answer.level_valid      = ok[k];
         answer.crossing_index   = INDEX_W'(where_at[k]);
         answer.deepest_plus_one = INDEX_W'(deepest + 1);
         answer.last_result      = (k == NUM_RESULTS - 1);
         answers_due.push_back(answer);
      end
      clear_profile();
   endfunction

   task automatic report(input level_answer_type want, input level_answer_type seen,
                         input bit unasked);
      mismatches++;
      if (mismatches > MAX_REPORTS) return;
      if (unasked)
         $display("%t: unexpected result: level %0d valid %0b index %0d deep+1 %0d last %0b",
                  $realtime, seen.level, seen.level_valid, seen.crossing_index,
                  seen.deepest_plus_one, seen.last_result);
      else
         $display("%t: expected level %0d valid %0b index %0d deep+1 %0d last %0b",
                  $realtime, want.level, want.level_valid, want.crossing_index,
                  want.deepest_plus_one, want.last_result);
      if (!unasked)
         $display("%t:      got level %0d valid %0b index %0d deep+1 %0d last %0b",
                  $realtime, seen.level, seen.level_valid, seen.crossing_index,
                  seen.deepest_plus_one, seen.last_result);
   endtask

   // Channels are sampled at the falling edge, ahead of the handshake edge,
   // where every signal has long settled.
   always @(negedge clock) begin : watch
      level_answer_type seen;
      level_answer_type want;
      if (reset) begin
         bottom_setting = BOTTOM_RESET;
         clear_profile();
         answers_due.delete();
         mismatches   = 0;
         answers_seen = 0;
         samples_seen = 0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            seen.level            = rsp_ch.level;
            seen.level_valid      = rsp_ch.level_valid;
            seen.crossing_index   = rsp_ch.crossing_index;
            seen.deepest_plus_one = rsp_ch.deepest_plus_one;
            seen.last_result      = rsp_ch.last_result;
            answers_seen++;
            if (answers_due.size() == 0) begin
               report(seen, seen, 1'b1);
            end else begin
               want = answers_due.pop_front();
               if (seen !== want) report(want, seen, 1'b0);
            end
         end
         if (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)
            bottom_setting = csr_ch.bottom_count;
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            samples_seen++;
            take_sample(req_ch.light_sample);
         end
      end
      answers_due_count = answers_due.size();
   end

endmodule

/* dv/light_profile_fraction_depth_finder_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the light profile fraction depth finder: clock, reset, stimulus,
// handshake idling and the verdict. Depends on lpfd_pkg, lpfd_ifs, the block itself
// and lpfd_depth_checker, which does all prediction and comparison.
module light_profile_fraction_depth_finder_tb;
   import lpfd_pkg::*;

   localparam int DEPTHS         = DEFAULT_DEPTHS;
   localparam int DRAIN_CYCLES   = 24;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_SAMPLES   = 16;
   localparam int PARTIAL_BOTTOM = 60;
   localparam int CLAMPED_BOTTOM = 127;
   localparam int TIMEOUT_NS     = 1_000_000;
   localparam longint BRIGHTEST = 8388607;
   localparam longint DARKEST   = -8388608;

   typedef enum {
      PROFILE_DECAY,
      PROFILE_GAPPY,
      PROFILE_FLAT,
      PROFILE_DARK,
      PROFILE_DEAD,
      PROFILE_BOUNDARY,
      PROFILE_NOISE
   } profile_kind_type;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_cycles;
   int   mismatches;
   int   answers_due_count;
   int   answers_seen;
   int   samples_seen;

   lpfd_req_if req_ch ();
   lpfd_rsp_if rsp_ch ();
   lpfd_csr_if csr_ch ();

   light_profile_fraction_depth_finder #(.DEPTHS(DEPTHS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   lpfd_depth_checker #(.DEPTHS(DEPTHS)) checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_ch),
      .rsp_ch            (rsp_ch),
      .csr_ch            (csr_ch),
      .mismatches        (mismatches),
      .answers_due_count (answers_due_count),
      .answers_seen      (answers_seen),
      .samples_seen      (samples_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("light_profile_fraction_depth_finder_tb: errors");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off counted down here.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one request, with random idle cycles ahead of it; returns at the accepting edge.
   task automatic send_sample(input longint value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.light_sample <= SAMPLE_W'(value);
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Sends one whole profile of DEPTHS samples, surface first.
   task automatic send_profile(input profile_kind_type kind, input longint top_light);
      longint lvl;
      longint value;
      lvl = top_light;
      for (int idx = 0; idx < DEPTHS; idx++) begin
         case (kind)
            PROFILE_FLAT: value = top_light;
            PROFILE_DARK: value = 0;
            // Surface 1000, then each fraction exactly, then just below it.
            PROFILE_BOUNDARY: begin
               if (idx == 0)
                  value = 1000;
               else if (idx <= 2 * NUM_LEVELS)
                  value = FRACTION_PER_MILLE[(idx - 1) / 2] - ((idx % 2 == 0) ? 1 : 0);
               else
                  value = 0;
            end
            PROFILE_NOISE: begin
               if (idx == 0)
                  value = BRIGHTEST;
               else if (idx == DEPTHS / 2)
                  value = DARKEST;
               else
                  value = longint'($urandom_range(16777215, 0)) + DARKEST;
            end
            default: begin
               value = lvl;
               if (idx == 0 && kind == PROFILE_DEAD)
                  value = DARKEST;
               else if (kind == PROFILE_GAPPY && $urandom_range(99) < 8)
                  value = -longint'($urandom_range(8388608, 1));
               lvl = (lvl * longint'($urandom_range(255, 200))) / 256;
            end
         endcase
         send_sample(value);
      end
   endtask

   // Stops offering requests until every owed result is back and the row has drained.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (answers_due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_bottom(input int count);
      settle();
      csr_ch.valid        <= 1'b1;
      csr_ch.bottom_count <= BOTTOM_W'(count);
      @(negedge clock);
      while (!csr_ch.ready) @(negedge clock);
      @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      send_idle_pct        = 17;
      recv_idle_pct        = 61;
      hold_cycles          = 0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.light_sample <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.bottom_count <= BOTTOM_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A flat profile over a partial search region leaves every level open and invalid.
      write_bottom(PARTIAL_BOTTOM);
      send_profile(PROFILE_FLAT, BRIGHTEST);

      // The sender waits for every result of the slow receiver before the bottom changes.
      write_bottom(CLAMPED_BOTTOM);

      // Slow sender and quick receiver; missing samples with a clamped bottom.
      send_idle_pct = 61;
      recv_idle_pct = 17;
      send_profile(PROFILE_GAPPY, BRIGHTEST);

      // The receiver holds off while exact boundaries stream in at full rate, so the
      // next end of profile finds the results still pending and the input stalls.
      send_idle_pct = 0;
      hold_cycles   = HOLD_CYCLES;
      send_profile(PROFILE_BOUNDARY, 1000);
      repeat (TAIL_SAMPLES) send_sample(longint'($urandom_range(8388607, 0)));
      req_ch.valid <= 1'b0;

      // The held profile drains with the quick receiver, the last one with no idling.
      while (answers_due_count > NUM_RESULTS) @(posedge clock);
      recv_idle_pct = 0;
      settle();

      $display("Run covered %0d samples in %0d full profiles and checked %0d level results,",
               samples_seen, samples_seen / DEPTHS, answers_seen);
      $display("with partial, clamped and exact boundary scans, missing samples, three idle");
      $display("mixes and a long receiver hold-off that stalled the input.");
      if (mismatches == 0 && answers_due_count == 0)
         $display("light_profile_fraction_depth_finder_tb: clean");
      else
         $display("light_profile_fraction_depth_finder_tb: errors");
      $finish;
   end

endmodule
